[hw/rtl/tspgb_pkg.sv]
// ----------------------------------------------------------------------------
// tspgb_pkg
// Types and constants for the timestamp pair grouping buffer.
// ----------------------------------------------------------------------------
package tspgb_pkg;

	localparam int LIST_DEPTH = 9;
	localparam int IDX_W      = $clog2(LIST_DEPTH);
	localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

	localparam logic KIND_DROPPED = 1'b0;
	localparam logic KIND_GROUP   = 1'b1;

	typedef struct packed {
		logic [63:0] frame_time;
		logic [7:0]  frame_tag;
	} frame_t;

	typedef struct packed {
		logic [7:0]  released_tag;
		logic [63:0] released_time;
		logic        release_kind;
		logic        last_of_run;
	} result_t;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_INS   = 6'b000010,
		ST_CHK   = 6'b000100,
		ST_ODROP = 6'b001000,
		ST_OG0   = 6'b010000,
		ST_OG1   = 6'b100000
	} state_t;

endpackage

[hw/rtl/timestamp_pair_grouping_buffer.sv]
// ----------------------------------------------------------------------------
// timestamp_pair_grouping_buffer
// Sorted list of pending frames; releases dropped heads and matched pairs.
// ----------------------------------------------------------------------------
// One frame is taken per start while busy is low. A full list first moves its
// head aside in the accept cycle; the new frame is then bubbled in from the
// tail through one shared 64-bit comparator, one list position per cycle, a
// check cycle compares the first two entries on the same comparator, and each
// release takes one cycle on the result ports, flagged by strobe. The receiver
// cannot stall: results must be taken the cycle they appear. Each frame causes
// 0 to 3 releases: first a dropped head, if any, then a matched pair, if any.
module timestamp_pair_grouping_buffer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  tspgb_pkg::frame_t frame,
	output logic              busy,
	output logic              strobe,
	output tspgb_pkg::result_t result
);
	import tspgb_pkg::*;

	state_t            state_q;
	logic [CNT_W-1:0]  count_q;
	logic [IDX_W-1:0]  pos_q;
	logic              drop_q;
	logic              grp_q;
	logic [63:0]       times_q [LIST_DEPTH];
	logic [7:0]        tags_q  [LIST_DEPTH];
	logic [63:0]       new_time_q;
	logic [7:0]        new_tag_q;
	logic [63:0]       drop_time_q;
	logic [7:0]        drop_tag_q;

	logic              accept;
	logic              full;
	logic [IDX_W-1:0]  rd_idx;
	logic [63:0]       cmp_a;
	logic [63:0]       cmp_b;
	logic              cmp_lt;
	logic              cmp_eq;
	logic              shift_on;
	logic              grp;

	assign accept   = start && (state_q == ST_IDLE);
	assign full     = (count_q == CNT_W'(LIST_DEPTH));
	assign rd_idx   = (pos_q == '0) ? '0 : pos_q - 1'b1;
	assign shift_on = (pos_q != '0) && cmp_lt;
	assign grp      = (count_q >= CNT_W'(2)) && cmp_eq;

	// shared comparator
	always_comb begin
		unique case (state_q)
			ST_CHK: begin
				cmp_a = times_q[0];
				cmp_b = times_q[1];
			end
			default: begin
				cmp_a = new_time_q;
				cmp_b = times_q[rd_idx];
			end
		endcase
	end

	assign cmp_lt = cmp_a < cmp_b;
	assign cmp_eq = cmp_a == cmp_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			pos_q   <= '0;
			drop_q  <= 1'b0;
			grp_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_INS;
						drop_q  <= full;
						if (full) begin
							count_q <= count_q - 1'b1;
							pos_q   <= IDX_W'(LIST_DEPTH - 1);
						end else begin
							pos_q <= count_q[IDX_W-1:0];
						end
					end
				end
				ST_INS: begin
					if (shift_on) begin
						pos_q <= pos_q - 1'b1;
					end else begin
						count_q <= count_q + 1'b1;
						state_q <= ST_CHK;
					end
				end
				ST_CHK: begin
					grp_q <= grp;
					if (drop_q)
						state_q <= ST_ODROP;
					else if (grp)
						state_q <= ST_OG0;
					else
						state_q <= ST_IDLE;
				end
				ST_ODROP: begin
					state_q <= grp_q ? ST_OG0 : ST_IDLE;
				end
				ST_OG0: begin
					state_q <= ST_OG1;
				end
				ST_OG1: begin
					count_q <= count_q - CNT_W'(2);
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// list storage, no reset
	always_ff @(posedge clk) begin
		if (accept) begin
			new_time_q <= frame.frame_time;
			new_tag_q  <= frame.frame_tag;
			if (full) begin
				drop_time_q <= times_q[0];
				drop_tag_q  <= tags_q[0];
				for (int i = 0; i < LIST_DEPTH - 1; i++) begin
					times_q[i] <= times_q[i+1];
					tags_q[i]  <= tags_q[i+1];
				end
			end
		end
		if (state_q == ST_INS) begin
			if (shift_on) begin
				times_q[pos_q] <= times_q[rd_idx];
				tags_q[pos_q]  <= tags_q[rd_idx];
			end else begin
				times_q[pos_q] <= new_time_q;
				tags_q[pos_q]  <= new_tag_q;
			end
		end
		if (state_q == ST_OG1) begin
			for (int i = 0; i < LIST_DEPTH - 2; i++) begin
				times_q[i] <= times_q[i+2];
				tags_q[i]  <= tags_q[i+2];
			end
		end
	end

	assign busy   = (state_q != ST_IDLE);
	assign strobe = (state_q == ST_ODROP) || (state_q == ST_OG0) || (state_q == ST_OG1);

	always_comb begin
		unique case (state_q)
			ST_ODROP: begin
				result.released_tag  = drop_tag_q;
				result.released_time = drop_time_q;
				result.release_kind  = KIND_DROPPED;
				result.last_of_run   = !grp_q;
			end
			ST_OG0: begin
				result.released_tag  = tags_q[0];
				result.released_time = times_q[0];
				result.release_kind  = KIND_GROUP;
				result.last_of_run   = 1'b0;
			end
			default: begin
				result.released_tag  = tags_q[1];
				result.released_time = times_q[1];
				result.release_kind  = KIND_GROUP;
				result.last_of_run   = 1'b1;
			end
		endcase
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(LIST_DEPTH))
		else $error("list count beyond depth");

	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> busy)
		else $error("result outside a transaction");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy && !strobe)
		else $error("accepted transaction did not start");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.last_of_run |=> !busy)
		else $error("activity after last result");

endmodule

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the timestamp pair grouping buffer. Frames go in
// through the start/busy handshake. A local sorted-list model predicts the
// dropped heads and the matched pairs that each frame causes. Every strobed
// result is checked field by field against the oldest prediction. Directed
// cases come first, then random pair-heavy traffic with idle bursts.
// ----------------------------------------------------------------------------
module tb_top;
	import tspgb_pkg::*;

	logic    clk    = 1'b0;
	logic    arst_n = 1'b0;
	logic    start  = 1'b0;
	frame_t  frame  = '0;
	logic    busy;
	logic    strobe;
	result_t result;

	logic [63:0] sorted_times [LIST_DEPTH];
	logic [7:0]  sorted_tags  [LIST_DEPTH];
	int          sorted_len = 0;
	result_t     pending_releases [$];
	int          err_count = 0;

	timestamp_pair_grouping_buffer i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.frame  (frame),
		.busy   (busy),
		.strobe (strobe),
		.result (result)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("DONE: errors detected");
		$finish;
	end

	function automatic void drop_front(input int n);
		for (int i = 0; i + n < sorted_len; i++) begin
			sorted_times[i] = sorted_times[i + n];
			sorted_tags[i]  = sorted_tags[i + n];
		end
		sorted_len -= n;
	endfunction

	function automatic result_t make_release(input int idx, input logic kind);
		result_t r;
		r.released_tag  = sorted_tags[idx];
		r.released_time = sorted_times[idx];
		r.release_kind  = kind;
		r.last_of_run   = 1'b0;
		return r;
	endfunction

	function automatic void predict_releases(input frame_t f);
		result_t batch [$];
		result_t r;
		int      pos;
		if (sorted_len >= LIST_DEPTH) begin
			batch.push_back(make_release(0, KIND_DROPPED));
			drop_front(1);
		end
		pos = 0;
		while (pos < sorted_len && !(f.frame_time < sorted_times[pos]))
			pos++;
		for (int i = sorted_len; i > pos; i--) begin
			sorted_times[i] = sorted_times[i - 1];
			sorted_tags[i]  = sorted_tags[i - 1];
		end
		sorted_times[pos] = f.frame_time;
		sorted_tags[pos]  = f.frame_tag;
		sorted_len++;
		if (sorted_len >= 2 && sorted_times[0] == sorted_times[1]) begin
			batch.push_back(make_release(0, KIND_GROUP));
			batch.push_back(make_release(1, KIND_GROUP));
			drop_front(2);
		end
		if (batch.size() > 0) begin
			r = batch[batch.size() - 1];
			r.last_of_run = 1'b1;
			batch[batch.size() - 1] = r;
		end
		foreach (batch[i])
			pending_releases.push_back(batch[i]);
	endfunction

	// one frame per transaction; start stays high for a following frame
	task automatic send_frame(input logic [63:0] t, input logic [7:0] tag);
		frame_t f;
		f.frame_time = t;
		f.frame_tag  = tag;
		start <= 1'b1;
		frame <= f;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		predict_releases(f);
	endtask

	task automatic idle_cycles(input int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic maybe_idle();
		if ($urandom_range(3) == 0)
			idle_cycles($urandom_range(1, 5));
	endtask

	always @(posedge clk) begin
		result_t exp_r;
		if (arst_n && strobe) begin
			if (pending_releases.size() == 0) begin
				$display("%0t: unexpected release, got %p", $time, result);
				err_count++;
			end else begin
				exp_r = pending_releases.pop_front();
				if (result.released_tag !== exp_r.released_tag) begin
					$display("%0t: released_tag expected %0h got %0h", $time,
						exp_r.released_tag, result.released_tag);
					err_count++;
				end
				if (result.released_time !== exp_r.released_time) begin
					$display("%0t: released_time expected %0h got %0h", $time,
						exp_r.released_time, result.released_time);
					err_count++;
				end
				if (result.release_kind !== exp_r.release_kind) begin
					$display("%0t: release_kind expected %0b got %0b", $time,
						exp_r.release_kind, result.release_kind);
					err_count++;
				end
				if (result.last_of_run !== exp_r.last_of_run) begin
					$display("%0t: last_of_run expected %0b got %0b", $time,
						exp_r.last_of_run, result.last_of_run);
					err_count++;
				end
			end
		end
	end

	task automatic test_extreme_pairs();
		send_frame(64'd0, 8'h00);
		send_frame(64'd0, 8'hff);
		maybe_idle();
		send_frame('1, 8'hff);
		send_frame('1, 8'h00);
	endtask

	// a pair behind the head is only released on the next insert
	task automatic test_deferred_pair();
		send_frame(64'd5, 8'h11);
		send_frame(64'd7, 8'h22);
		maybe_idle();
		send_frame(64'd7, 8'h33);
		send_frame(64'd5, 8'h44);
		send_frame(64'd8, 8'h55);
	endtask

	// fill in descending order, release a pair, then refill and drop the head
	task automatic test_full_list();
		for (int i = 8; i >= 1; i--) begin
			send_frame(64'd100 * i, 8'(i));
			maybe_idle();
		end
		send_frame(64'd100, 8'hf0);
		send_frame(64'd900, 8'h09);
		send_frame(64'd1000, 8'h0a);
		send_frame(64'd50, 8'h05);
	endtask

	task automatic test_random_pairs(input int n_items, input int quiet_tail);
		logic [63:0] recent [$];
		logic [63:0] cursor;
		logic [63:0] t;
		int          sel;
		cursor = {$urandom, $urandom};
		for (int i = 0; i < n_items; i++) begin
			sel = $urandom_range(99);
			if (recent.size() > 0 && sel < 55)
				t = recent[$urandom_range(recent.size() - 1)];
			else if (sel < 78)
				t = {$urandom, $urandom};
			else if (sel < 96) begin
				cursor = cursor + 64'($urandom_range(1, 3));
				t = cursor;
			end else
				t = (sel < 98) ? 64'd0 : '1;
			recent.push_back(t);
			if (recent.size() > 12)
				void'(recent.pop_front());
			send_frame(t, 8'($urandom_range(255)));
			if (i < n_items - quiet_tail)
				maybe_idle();
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extreme_pairs();
		test_deferred_pair();
		test_full_list();
		test_random_pairs(388, 60);
		start <= 1'b0;
		while (pending_releases.size() != 0)
			@(posedge clk);
		repeat (LIST_DEPTH + 10) @(posedge clk);
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

[files.f]
hw/rtl/tspgb_pkg.sv
hw/rtl/timestamp_pair_grouping_buffer.sv
verif/tb_top.sv
